FILE: design/sli_pkg.sv
// Shared constants, opcodes and controller command type for the sorted list block.
package sli_pkg;

  // Storage size and derived widths
  localparam int CAPACITY = 16;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int INDEX_W  = 4;
  localparam int VALUE_W  = 32;
  localparam int CMP_W    = (COUNT_W > INDEX_W) ? COUNT_W : INDEX_W;

  // Fixed field widths of the result
  localparam int ENTRY_COUNT_W = 5;

  // Stream payload widths, padded to whole bytes
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 40;

  // Operation codes
  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_INSERT = 2'd0;
  localparam opcode_t OP_DELETE = 2'd1;
  localparam opcode_t OP_READ   = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;  // capture the incoming transaction
    logic exec;  // apply the operation and load the result register
  } sli_cmd_t;

endpackage

FILE: design/sli_ctrl.sv
// Controller state machine: sequences capture, execute and result handoff.
module sli_ctrl import sli_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output sli_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   accept;

  // Take a new transaction only when idle and the result slot is free or draining
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  assign cmd.load = accept;
  assign cmd.exec = (state == S_EXEC);

  // State and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/sli_datapath.sv
// Datapath: sorted shift-register array with parallel compares and result register.
module sli_datapath import sli_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  sli_cmd_t                  cmd,
  input  opcode_t                   in_opcode,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [INDEX_W-1:0]        in_index,
  output logic [COUNT_W-1:0]        res_count,
  output logic                      res_done,
  output logic                      res_drop,
  output logic signed [VALUE_W-1:0] res_value
);

  // Captured transaction
  opcode_t                   op_q;
  logic signed [VALUE_W-1:0] val_q;
  logic [INDEX_W-1:0]        idx_q;

  // Storage
  logic signed [VALUE_W-1:0] entries [CAPACITY];
  logic [COUNT_W-1:0]        count;

  // Per-slot compare results
  logic [CAPACITY-1:0] valid;
  logic [CAPACITY-1:0] at_pos;   // slot is at or after the insert point
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] del_past; // slot is at or after the first match

  logic signed [VALUE_W-1:0] ins_next [CAPACITY];
  logic signed [VALUE_W-1:0] del_next [CAPACITY];
  logic signed [VALUE_W-1:0] rd_data;
  logic                      rd_ok;
  logic                      is_full;
  logic                      found;

  // Capture input
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_opcode;
      val_q <= in_value;
      idx_q <= in_index;
    end
  end

  // Slot compares, one per entry
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i]  = (COUNT_W'(i) < count);
      at_pos[i] = !valid[i] || (entries[i] >= val_q);
      match[i]  = valid[i] && (entries[i] == val_q);
    end
  end

  // First-match prefix for delete, each slot reduced on its own
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      del_past[i] = 1'b0;
      for (int j = 0; j <= i; j++) begin
        del_past[i] = del_past[i] | match[j];
      end
    end
  end

  assign found   = |match;
  assign is_full = (count >= COUNT_W'(CAPACITY));

  // Next array contents for insert (shift up) and delete (shift down)
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (!at_pos[i]) begin
        ins_next[i] = entries[i];
      end else if (i == 0) begin
        ins_next[i] = val_q;
      end else if (!at_pos[i-1]) begin
        ins_next[i] = val_q;
      end else begin
        ins_next[i] = entries[i-1];
      end

      if (!del_past[i]) begin
        del_next[i] = entries[i];
      end else if (i == CAPACITY - 1) begin
        del_next[i] = '0;
      end else begin
        del_next[i] = entries[i+1];
      end
    end
  end

  // Read port: select by index
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CMP_W'(idx_q) == CMP_W'(i)) begin
        rd_data = entries[i];
      end
    end
    rd_ok = (CMP_W'(idx_q) < CMP_W'(count));
  end

  // Apply operation and register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        entries[i] <= '0;
      end
    end else if (cmd.exec) begin
      res_count <= count;
      res_done  <= 1'b0;
      res_drop  <= 1'b0;
      res_value <= '0;
      case (op_q)
        OP_INSERT: begin
          if (is_full) begin
            res_drop <= 1'b1;
          end else begin
            entries   <= ins_next;
            count     <= count + COUNT_W'(1);
            res_count <= count + COUNT_W'(1);
            res_done  <= 1'b1;
          end
        end
        OP_DELETE: begin
          if (found) begin
            entries   <= del_next;
            count     <= count - COUNT_W'(1);
            res_count <= count - COUNT_W'(1);
            res_done  <= 1'b1;
          end
        end
        OP_READ: begin
          if (rd_ok) begin
            res_value <= rd_data;
            res_done  <= 1'b1;
          end
        end
        default: begin
          // unused opcode: report count only
        end
      endcase
    end
  end

endmodule

FILE: design/sorted_list_insert_delete.sv
// Sorted list of signed 32-bit values with ordered insert, delete and indexed read.
//
// Input stream (s_*): one transaction per operation: opcode, value, index.
//   Insert puts value ahead of the first entry >= value; full list drops it.
//   Delete removes the first entry equal to value. Read returns entry[index].
// Output stream (m_*): exactly one result transaction per operation, with the
//   entry count after the operation, done flag, full-drop flag and read value.
// Timing: an accepted transaction is captured, executed the next cycle, and its
//   result is registered in the execute step. One operation is in flight at a
//   time, so a new transaction waits until the controller goes from its capture
//   and execute steps back to idle; the shift-array update is the execute step.
// All 16 slots are compared in parallel; the array shifts up or down in the execute step.
// Reset (rst, synchronous) empties the list and clears every slot to zero.
// Stalls: the result register holds while m_tready is low; s_tready stays low
//   until that result is taken, then a new transaction may enter in the same cycle.
module sorted_list_insert_delete import sli_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // opcode[1:0], value[33:2], index[37:34], zero pad
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata   // entry_count[4:0], done_res[5], full_drop[6],
                                        // read_value[38:7], zero pad
);

  sli_cmd_t                  cmd;
  logic [COUNT_W-1:0]        res_count;
  logic                      res_done;
  logic                      res_drop;
  logic signed [VALUE_W-1:0] res_value;

  // Controller
  sli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  // Datapath
  sli_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_opcode (opcode_t'(s_tdata[1:0])),
    .in_value  ($signed(s_tdata[33:2])),
    .in_index  (s_tdata[37:34]),
    .res_count (res_count),
    .res_done  (res_done),
    .res_drop  (res_drop),
    .res_value (res_value)
  );

  // Result packing
  assign m_tdata = {1'b0, res_value, res_drop, res_done, ENTRY_COUNT_W'(res_count)};

  // Checks
  a_exec_follows_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> cmd.exec)
    else $error("accepted transaction not executed next cycle");

  a_exec_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> m_tvalid)
    else $error("execute did not present a result");

  a_no_accept_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while result stalled");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[4:0] <= ENTRY_COUNT_W'(CAPACITY)))
    else $error("entry count exceeds capacity");

endmodule
